### rtl/pfrp_pkg.sv
`timescale 1ns / 1ps

package pfrp_pkg;

  localparam logic [15:0] CRC_POLY     = 16'h1021;
  localparam logic [7:0]  HEADER_RESET = 8'h69;

  // Frame commands carried in byte 1
  localparam logic [7:0] CMD_PAIR_REQ = 8'h00;
  localparam logic [7:0] CMD_PAIR_RSP = 8'h01;
  localparam logic [7:0] CMD_FLUSH    = 8'h02;
  localparam logic [7:0] CMD_DATA     = 8'h03;

  // Configuration register indexes
  localparam logic [1:0] REG_FRAME_HEADER = 2'd0;

  typedef enum logic [1:0] {
    OP_FRAME_BYTE = 2'd0,
    OP_TICK       = 2'd1,
    OP_START      = 2'd2,
    OP_UNPAIR     = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    LINK_NOT_PAIRED = 2'd0,
    LINK_PAIRING    = 2'd1,
    LINK_PAIRED     = 2'd2
  } link_t;

  typedef enum logic [2:0] {
    VERD_NONE     = 3'd0,
    VERD_DATA_OK  = 3'd1,
    VERD_PAIRED   = 3'd2,
    VERD_UNPAIRED = 3'd3,
    VERD_BAD_HDR  = 3'd4,
    VERD_BAD_CRC  = 3'd5,
    VERD_IGNORED  = 3'd6
  } verdict_t;

  typedef enum logic [1:0] {
    SREQ_NONE     = 2'd0,
    SREQ_PAIR_REQ = 2'd1,
    SREQ_PAIR_RSP = 2'd2,
    SREQ_FLUSH    = 2'd3
  } sreq_t;

  typedef struct packed {
    op_t         op;
    logic [7:0]  rx_byte;
    logic        frame_last;
    logic [47:0] source_address;
    logic [15:0] attempts;
  } item_t;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        payload_valid;
    logic        payload_last;
    verdict_t    frame_verdict;
    link_t       pairing_status;
    sreq_t       send_request;
    logic [47:0] peer_address;
    logic        pairing_failed;
  } result_t;

  // MSB-first CRC-16 over one byte, no reflection
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

### rtl/pfrp_ifs.sv
`timescale 1ns / 1ps

interface pfrp_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [7:0]  rx_byte;
  logic        frame_last;
  logic [47:0] source_address;
  logic [15:0] attempts;

  modport source (output valid, op, rx_byte, frame_last, source_address, attempts,
                  input ready);
  modport sink (input valid, op, rx_byte, frame_last, source_address, attempts,
                output ready);
endinterface

interface pfrp_result_if;
  logic        valid;
  logic        ready;
  logic [7:0]  payload_byte;
  logic        payload_valid;
  logic        payload_last;
  logic [2:0]  frame_verdict;
  logic [1:0]  pairing_status;
  logic [1:0]  send_request;
  logic [47:0] peer_address;
  logic        pairing_failed;

  modport source (output valid, payload_byte, payload_valid, payload_last, frame_verdict,
                  pairing_status, send_request, peer_address, pairing_failed,
                  input ready);
  modport sink (input valid, payload_byte, payload_valid, payload_last, frame_verdict,
                pairing_status, send_request, peer_address, pairing_failed,
                output ready);
endinterface

### rtl/pfrp_apb_regs.sv
`timescale 1ns / 1ps

module pfrp_apb_regs (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [7:0]  frame_header
);
  import pfrp_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_header <= HEADER_RESET;
    end else if (wr_en && (paddr == REG_FRAME_HEADER)) begin
      frame_header <= pwdata[7:0];
    end
  end

  always_comb begin
    unique case (paddr)
      REG_FRAME_HEADER: prdata = {24'h000000, frame_header};
      default:          prdata = '0;
    endcase
  end

endmodule

### rtl/pfrp_link_core.sv
`timescale 1ns / 1ps

module pfrp_link_core #(
  parameter int MAX_FRAME_BYTES = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  pfrp_pkg::item_t   item,
  input  logic [7:0]        frame_header,
  output pfrp_pkg::result_t res
);
  import pfrp_pkg::*;

  localparam int CW = $clog2(MAX_FRAME_BYTES + 2);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_FRAME_BYTES);

  link_t         link,        link_next;
  logic [47:0]   peer,        peer_next;
  logic [15:0]   retries,     retries_next;
  logic          timer,       timer_next;
  logic [15:0]   crc,         crc_next;
  logic [CW-1:0] count,       count_next;
  logic [7:0]    dly0,        dly0_next;
  logic [7:0]    dly1,        dly1_next;
  logic [7:0]    cmd,         cmd_next;
  logic          hdr_ok,      hdr_ok_next;

  logic          src_is_peer;
  logic [15:0]   retries_dec;

  assign src_is_peer = (item.source_address == peer);
  assign retries_dec = (retries != 16'd0) ? retries - 16'd1 : retries;

  always_comb begin
    link_next    = link;
    peer_next    = peer;
    retries_next = retries;
    timer_next   = timer;
    crc_next     = crc;
    count_next   = count;
    dly0_next    = dly0;
    dly1_next    = dly1;
    cmd_next     = cmd;
    hdr_ok_next  = hdr_ok;
    res          = '0;

    unique case (item.op)
      OP_FRAME_BYTE: begin
        if (count == '0) begin
          hdr_ok_next = (item.rx_byte == frame_header);
        end else if (count == CW'(1)) begin
          cmd_next = item.rx_byte;
        end
        if (count >= CW'(2)) begin
          crc_next = crc_feed(crc, dly1);
          if (count >= CW'(4) && count < CNT_MAX && hdr_ok && cmd == CMD_DATA &&
              link == LINK_PAIRED && src_is_peer) begin
            res.payload_byte  = dly1;
            res.payload_valid = 1'b1;
            res.payload_last  = item.frame_last;
          end
        end
        if (item.frame_last) begin
          // Length is count + 1; too short below four, too long above the maximum
          if (count < CW'(3) || count >= CNT_MAX) begin
            res.frame_verdict = VERD_IGNORED;
          end else if (!hdr_ok) begin
            res.frame_verdict = VERD_BAD_HDR;
          end else if (crc_next != {item.rx_byte, dly0}) begin
            res.frame_verdict = VERD_BAD_CRC;
          end else begin
            res.frame_verdict = VERD_IGNORED;
            case (cmd) inside
              CMD_PAIR_REQ, CMD_PAIR_RSP: begin
                if (link == LINK_PAIRING) begin
                  timer_next        = 1'b0;
                  retries_next      = '0;
                  peer_next         = item.source_address;
                  link_next         = LINK_PAIRED;
                  res.frame_verdict = VERD_PAIRED;
                  if (cmd == CMD_PAIR_REQ) begin
                    res.send_request = SREQ_PAIR_RSP;
                  end
                end
              end
              CMD_FLUSH: begin
                if (link == LINK_PAIRED && src_is_peer) begin
                  peer_next         = '0;
                  link_next         = LINK_NOT_PAIRED;
                  res.frame_verdict = VERD_UNPAIRED;
                end
              end
              CMD_DATA: begin
                if (link == LINK_PAIRED && src_is_peer) begin
                  res.frame_verdict = VERD_DATA_OK;
                end
              end
              default: ;
            endcase
          end
          crc_next    = '0;
          count_next  = '0;
          dly0_next   = '0;
          dly1_next   = '0;
          cmd_next    = '0;
          hdr_ok_next = 1'b0;
        end else begin
          dly1_next = dly0;
          dly0_next = item.rx_byte;
          if (count <= CNT_MAX) begin
            count_next = count + CW'(1);
          end
        end
      end
      OP_TICK: begin
        if (timer) begin
          retries_next = retries_dec;
          if (retries_dec == 16'd0) begin
            link_next          = LINK_NOT_PAIRED;
            timer_next         = 1'b0;
            res.pairing_failed = 1'b1;
          end else begin
            res.send_request = SREQ_PAIR_REQ;
          end
        end
      end
      OP_START: begin
        if (link == LINK_NOT_PAIRED) begin
          res.send_request = SREQ_PAIR_REQ;
          link_next        = LINK_PAIRING;
          retries_next     = item.attempts;
          timer_next       = (item.attempts != 16'd0);
        end
      end
      OP_UNPAIR: begin
        if (link == LINK_PAIRED) begin
          res.send_request = SREQ_FLUSH;
          peer_next        = '0;
          link_next        = LINK_NOT_PAIRED;
        end
      end
      default: ;
    endcase

    res.pairing_status = link_next;
    res.peer_address   = peer_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      link    <= LINK_NOT_PAIRED;
      peer    <= '0;
      retries <= '0;
      timer   <= 1'b0;
      crc     <= '0;
      count   <= '0;
      dly0    <= '0;
      dly1    <= '0;
      cmd     <= '0;
      hdr_ok  <= 1'b0;
    end else if (advance) begin
      link    <= link_next;
      peer    <= peer_next;
      retries <= retries_next;
      timer   <= timer_next;
      crc     <= crc_next;
      count   <= count_next;
      dly0    <= dly0_next;
      dly1    <= dly1_next;
      cmd     <= cmd_next;
      hdr_ok  <= hdr_ok_next;
    end
  end

endmodule

### rtl/peer_frame_receiver_pairing_core.sv
`timescale 1ns / 1ps

// Channel     Direction  Handshake      Carries
// item_in     sink       valid / ready  op, rx_byte, frame_last, source_address, attempts
// result_out  source     valid / ready  payload, verdict, pairing status, send request
// apb         slave      psel/penable   frame_header register at byte address 0
//
// Each item is held in the input register and passes through the core logic before
// its result lands in the result register; one item per cycle is sustained while
// result_out does not stall, set by the single CRC byte step and peer compare in between.
// Synchronous reset rst clears link state, frame tracking and both valid flags.
// A stall on result_out holds the result register; the input register keeps taking
// items as long as its contents can move on in the same cycle.

module peer_frame_receiver_pairing_core #(
  parameter int MAX_FRAME_BYTES = 256
) (
  input  logic               clk,
  input  logic               rst,
  pfrp_item_if.sink          item_in,
  pfrp_result_if.source      result_out,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [1:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import pfrp_pkg::*;

  logic [7:0]  hdr_value;

  // Input register
  logic        in_valid;
  item_t       in_item;

  // Result register
  logic        out_valid;
  result_t     out_res;

  result_t     core_res;
  logic        advance;

  pfrp_apb_regs u_regs (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .frame_header (hdr_value)
  );

  // Move the held item into the result register when that register is free or draining
  assign advance       = in_valid && (!out_valid || result_out.ready);
  assign item_in.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (item_in.ready) begin
      in_valid <= item_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_in.ready && item_in.valid) begin
      in_item.op             <= op_t'(item_in.op);
      in_item.rx_byte        <= item_in.rx_byte;
      in_item.frame_last     <= item_in.frame_last;
      in_item.source_address <= item_in.source_address;
      in_item.attempts       <= item_in.attempts;
    end
  end

  pfrp_link_core #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .item         (in_item),
    .frame_header (hdr_value),
    .res          (core_res)
  );

  // Hold the result until taken; drop the valid once drained with nothing behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= core_res;
    end
  end

  assign result_out.valid          = out_valid;
  assign result_out.payload_byte   = out_res.payload_byte;
  assign result_out.payload_valid  = out_res.payload_valid;
  assign result_out.payload_last   = out_res.payload_last;
  assign result_out.frame_verdict  = out_res.frame_verdict;
  assign result_out.pairing_status = out_res.pairing_status;
  assign result_out.send_request   = out_res.send_request;
  assign result_out.peer_address   = out_res.peer_address;
  assign result_out.pairing_failed = out_res.pairing_failed;

endmodule
